FILE: rtl/core/dsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsg_pkg
// Item codes shared by the domino shuffling grid engine.
// ----------------------------------------------------------------------------
package dsg_pkg;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_GROW   = 2'd1,
      ACT_CREATE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

endpackage
`default_nettype wire

FILE: rtl/core/dsg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/dsg_slide_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsg_slide_unit
// Annihilate and slide one row pair of the padded block lattice.
// ----------------------------------------------------------------------------
module dsg_slide_unit #(
   parameter int GDIM = 128,
   parameter int OW   = 7
) (
   input  wire logic [GDIM-1:0] top_row,
   input  wire logic [GDIM-1:0] bot_row,
   input  wire logic            row_p1,
   input  wire logic [OW-1:0]   order_new,
   output logic      [GDIM-1:0] new_top,
   output logic      [GDIM-1:0] new_bot
);

   always_comb begin
      logic [GDIM+1:0] ext_t;
      logic [GDIM+1:0] ext_b;
      logic [GDIM-1:0] mask;
      logic            a, b, c, d;
      ext_t = {1'b0, top_row, 1'b0};
      ext_b = {1'b0, bot_row, 1'b0};
      for (int j = 0; j <= GDIM / 2; j++) begin
         a = ext_t[2*j];
         b = ext_t[2*j+1];
         c = ext_b[2*j];
         d = ext_b[2*j+1];
         // annihilate opposing pair
         if (row_p1 && (j < int'(order_new))) begin
            if (a && d) begin
               a = 1'b0;
               d = 1'b0;
            end else if (b && c) begin
               b = 1'b0;
               c = 1'b0;
            end
         end
         // slide first set corner to the opposite one
         if (d) begin
            a = 1'b1;
            d = 1'b0;
         end else if (a) begin
            a = 1'b0;
            d = 1'b1;
         end else if (c) begin
            b = 1'b1;
            c = 1'b0;
         end else if (b) begin
            c = 1'b1;
            b = 1'b0;
         end
         ext_t[2*j]   = a;
         ext_t[2*j+1] = b;
         ext_b[2*j]   = c;
         ext_b[2*j+1] = d;
      end
      for (int k = 0; k < GDIM; k++) begin
         mask[k] = (k < 2 * int'(order_new));
      end
      new_top = ext_t[GDIM:1] & mask;
      new_bot = ext_b[GDIM:1] & mask;
   end

endmodule
`default_nettype wire

FILE: rtl/core/domino_shuffling_grid_step_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// domino_shuffling_grid_step_core
// Aztec diamond domino shuffling engine on a row-organized bit grid.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (req_*) carry an action, a row, a column, a threshold and a
//   toss. Only a read produces a response beat (rsp_cell_res); start, grow and
//   create produce none. The grid sits in a RAM with one grid row per word,
//   and one row-wide slide unit is reused for each block row of a grow.
//   A start clears every row of the grid; a grow or create that is ignored
//   leaves the block idle.
//   req_stall is high while a beat is in progress. A read result is held in
//   an output register; the next request is taken while it waits, and a
//   following read holds in its last step until the register is free.
//   After reset the block runs a clearing pass over all 2*MAX_ORDER rows, one
//   row a cycle, with req_stall high; order resets to zero.
//   A stalled response holds value and valid until taken.
// ----------------------------------------------------------------------------
module domino_shuffling_grid_step_core #(
   parameter int MAX_ORDER = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [6:0]  req_row,
   input  wire logic [6:0]  req_col,
   input  wire logic [32:0] req_threshold,
   input  wire logic [31:0] req_toss,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_cell_res
);

   localparam int GDIM = 2 * MAX_ORDER;
   localparam int AW   = (GDIM > 1) ? $clog2(GDIM) : 1;
   localparam int OW   = $clog2(MAX_ORDER + 1);
   localparam int EW   = ((AW > 8) ? AW : 8) + 1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_G_RDT,
      S_G_RDB,
      S_G_LAT,
      S_G_WRT,
      S_G_WRB,
      S_C_RD,
      S_C_WR0,
      S_C_WR1,
      S_R_RD,
      S_R_OUT
   } state_type;

   state_type       state_ff;
   logic [OW-1:0]   order_ff;
   logic [AW-1:0]   cnt_ff;
   logic [OW-1:0]   bi_ff;
   logic [GDIM-1:0] top_ff;
   logic [GDIM-1:0] bot_ff;
   logic [GDIM-1:0] crow_ff [4];
   logic [2:0]      ck_ff;
   logic            win_ff;
   logic            start_ff;
   logic [6:0]      rowr_ff;
   logic [6:0]      colr_ff;
   logic            rsp_valid_ff;
   logic            rsp_cell_res_ff;

   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [GDIM-1:0] ram_wdata;
   logic [AW-1:0]   ram_raddr;
   logic [GDIM-1:0] ram_rdata;

   logic [GDIM-1:0] new_top;
   logic [GDIM-1:0] new_bot;
   logic            req_take;
   logic            req_win;
   logic            rsp_free;
   logic [OW:0]     g_top_addr;
   logic [OW:0]     g_bot_addr;
   logic [EW-1:0]   c_addr;
   logic [7:0]      cbase;
   logic [GDIM:0]   cext [4];
   logic            c_ok;
   logic            c_lo_ok;
   logic            c_hi_ok;
   logic [GDIM-1:0] bit_c0;
   logic [GDIM-1:0] bit_c1;
   logic [OW:0]     order2;
   logic [2:0]      ck_prev;
   logic [GDIM-1:0] clr_row;

   dsg_ram #(
      .WIDTH (GDIM),
      .DEPTH (GDIM)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dsg_slide_unit #(
      .GDIM (GDIM),
      .OW   (OW)
   ) u_slide (
      .top_row   (top_ff),
      .bot_row   (bot_ff),
      .row_p1    (bi_ff < order_ff),
      .order_new (order_ff),
      .new_top   (new_top),
      .new_bot   (new_bot)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign req_win   = ({1'b0, req_toss} < req_threshold);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign order2    = {order_ff, 1'b0};

   // block row i covers grid rows 2i-1 and 2i
   assign g_top_addr = {bi_ff, 1'b0} - {{OW{1'b0}}, 1'b1};
   assign g_bot_addr = {bi_ff, 1'b0};
   assign c_addr     = EW'({rowr_ff, 1'b0}) + EW'(ck_ff) - EW'(1);
   assign cbase      = {colr_ff, 1'b0};
   assign ck_prev    = ck_ff - 3'd1;

   // create: window of grid columns 2c-1 .. 2c+2 for grid rows 2r-1 .. 2r+2
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cext[k] = {crow_ff[k], 1'b0} >> cbase;
      end
      c_lo_ok = (rowr_ff != 7'd0);
      c_hi_ok = ({1'b0, rowr_ff} + 8'd1) < order_ff;
      c_ok = !(cext[1][0] | cext[1][1] | cext[1][2] | cext[1][3] |
               cext[2][0] | cext[2][1] | cext[2][2] | cext[2][3]) &&
             !(c_lo_ok && (cext[0][1] | cext[0][2])) &&
             !(c_hi_ok && (cext[3][1] | cext[3][2]));
      bit_c0 = GDIM'(1) << cbase;
      bit_c1 = GDIM'(2) << cbase;
   end

   always_comb begin
      clr_row = '0;
      if (start_ff && (cnt_ff == AW'(0))) begin
         clr_row = win_ff ? GDIM'(1) : GDIM'(2);
      end else if (start_ff && (cnt_ff == AW'(1))) begin
         clr_row = win_ff ? GDIM'(2) : GDIM'(1);
      end
   end

   // RAM port steering
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = clr_row;
      ram_raddr = AW'(rowr_ff);
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
         end
         S_G_RDT: begin
            ram_raddr = AW'(g_top_addr);
         end
         S_G_RDB: begin
            ram_raddr = AW'(g_bot_addr);
         end
         S_G_WRT: begin
            ram_we    = (bi_ff != OW'(0));
            ram_waddr = AW'(g_top_addr);
            ram_wdata = new_top;
         end
         S_G_WRB: begin
            ram_we    = (bi_ff != order_ff);
            ram_waddr = AW'(g_bot_addr);
            ram_wdata = new_bot;
         end
         S_C_RD: begin
            ram_raddr = AW'(c_addr);
         end
         S_C_WR0: begin
            ram_we    = c_ok;
            ram_waddr = AW'({rowr_ff, 1'b0});
            ram_wdata = crow_ff[1] | (win_ff ? bit_c0 : bit_c1);
         end
         S_C_WR1: begin
            ram_we    = c_ok;
            ram_waddr = AW'({rowr_ff, 1'b1});
            ram_wdata = crow_ff[2] | (win_ff ? bit_c1 : bit_c0);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         order_ff     <= '0;
         cnt_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a taken response unless a new one loads this cycle
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_R_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               // sweep one row a cycle
               if (cnt_ff == AW'(GDIM - 1)) begin
                  state_ff <= S_IDLE;
               end
               cnt_ff <= cnt_ff + AW'(1);
            end
            S_IDLE: begin
               if (req_take) begin
                  rowr_ff <= req_row;
                  colr_ff <= req_col;
                  win_ff  <= req_win;
                  case (dsg_pkg::action_type'(req_action))
                     dsg_pkg::ACT_START: begin
                        order_ff <= OW'(1);
                        start_ff <= 1'b1;
                        cnt_ff   <= '0;
                        state_ff <= S_CLEAR;
                     end
                     dsg_pkg::ACT_GROW: begin
                        if (order_ff < OW'(MAX_ORDER)) begin
                           order_ff <= order_ff + OW'(1);
                           bi_ff    <= '0;
                           state_ff <= S_G_RDT;
                        end
                     end
                     dsg_pkg::ACT_CREATE: begin
                        if ((req_row < order_ff) && (req_col < order_ff)) begin
                           ck_ff    <= '0;
                           state_ff <= S_C_RD;
                        end
                     end
                     default: begin
                        state_ff <= S_R_RD;
                     end
                  endcase
               end
            end
            S_G_RDT: begin
               state_ff <= S_G_RDB;
            end
            S_G_RDB: begin
               top_ff   <= (bi_ff == OW'(0)) ? '0 : ram_rdata;
               state_ff <= S_G_LAT;
            end
            S_G_LAT: begin
               bot_ff   <= (bi_ff == order_ff) ? '0 : ram_rdata;
               state_ff <= S_G_WRT;
            end
            S_G_WRT: begin
               state_ff <= S_G_WRB;
            end
            S_G_WRB: begin
               if (bi_ff == order_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  bi_ff    <= bi_ff + OW'(1);
                  state_ff <= S_G_RDT;
               end
            end
            S_C_RD: begin
               // capture the row requested last cycle
               if (ck_ff != 3'd0) begin
                  crow_ff[ck_prev[1:0]] <= ram_rdata;
               end
               if (ck_ff == 3'd4) begin
                  state_ff <= S_C_WR0;
               end else begin
                  ck_ff <= ck_ff + 3'd1;
               end
            end
            S_C_WR0: begin
               state_ff <= S_C_WR1;
            end
            S_C_WR1: begin
               state_ff <= S_IDLE;
            end
            S_R_RD: begin
               state_ff <= S_R_OUT;
            end
            S_R_OUT: begin
               // hold until the response register is free
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_cell_res_ff <= (rowr_ff < order2) && (colr_ff < order2) &&
                                     ram_rdata[AW'(colr_ff)];
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_res = rsp_cell_res_ff;

`ifndef SYNTHESIS
   a_order_step: assert property (@(posedge clock) disable iff (reset)
      (order_ff != $past(order_ff)) |->
         ((order_ff == $past(order_ff) + OW'(1)) || (order_ff == OW'(1))))
      else $error("order moved by more than one");

   a_order_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_G_RDT) |-> (order_ff <= OW'(MAX_ORDER)))
      else $error("grow beyond maximum order");

   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (req_stall && (ram_we == 1'b1)))
      else $error("clear sweep not exclusive");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_R_OUT))
      else $error("response beat without a read");
`endif

endmodule
`default_nettype wire
